[src/psqrl_pkg.sv]
// Shared types and constants for the per-source query rate limiter.
package psqrl_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned TickW = 32;

  // Window length after reset: five seconds of millisecond ticks
  localparam logic [TickW-1:0] WindowReset = TickW'(5 * 1000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESP
  } psqrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // latch request, restart the scan
    logic scan;      // step the table scan
    logic commit;    // write the request into its slot
    logic load_out;  // load the verdict into the output register
  } psqrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;   // live entry with the same address seen this cycle
    logic last;  // final entry evaluated this cycle
  } psqrl_status_t;

endpackage

[src/psqrl_ctrl.sv]
// Sequencing state machine and output valid register of the rate limiter.
module psqrl_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  input  psqrl_pkg::psqrl_status_t status_i,
  output psqrl_pkg::psqrl_cmd_t    cmd_o
);

  psqrl_pkg::psqrl_state_e state_q, state_d;
  logic                    out_valid_q, out_valid_d;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psqrl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      psqrl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = psqrl_pkg::ST_SCAN;
        end
      end
      psqrl_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit) begin
          state_d = psqrl_pkg::ST_RESP;
        end else if (status_i.last) begin
          state_d = psqrl_pkg::ST_WRITE;
        end
      end
      psqrl_pkg::ST_WRITE: begin
        cmd_o.commit = 1'b1;
        state_d      = psqrl_pkg::ST_RESP;
      end
      psqrl_pkg::ST_RESP: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = psqrl_pkg::ST_IDLE;
        end
      end
      default: state_d = psqrl_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.load_out;
  assign out_valid_o = out_valid_q;

endmodule

[src/psqrl_datapath.sv]
// Slot table, scan evaluation and window register of the rate limiter.
module psqrl_datapath #(
  parameter int unsigned TableDepth = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  psqrl_pkg::psqrl_cmd_t           cmd_i,
  output psqrl_pkg::psqrl_status_t        status_o,
  input  logic [psqrl_pkg::AddrW-1:0]     source_address_i,
  input  logic [psqrl_pkg::TickW-1:0]     now_ticks_i,
  input  logic                            cfg_we_i,
  input  logic [psqrl_pkg::TickW-1:0]     cfg_wdata_i,
  output logic                            accepted_o
);

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  // Slot storage: single read port, single write port
  logic [psqrl_pkg::AddrW-1:0] mem_addr  [TableDepth];
  logic [psqrl_pkg::TickW-1:0] mem_stamp [TableDepth];

  logic [psqrl_pkg::TickW-1:0] window_q;
  logic [psqrl_pkg::AddrW-1:0] addr_q;
  logic [psqrl_pkg::TickW-1:0] now_q;
  logic [TableDepth-1:0]       valid_q, valid_d;
  logic [TableDepth-1:0]       live_q;
  logic [CntW-1:0]             rd_cnt_q;
  logic                        ev_vld_q;
  logic [IdxW-1:0]             ev_idx_q;
  logic [psqrl_pkg::AddrW-1:0] rd_addr_q;
  logic [psqrl_pkg::TickW-1:0] rd_stamp_q;
  logic                        free_found_q;
  logic [IdxW-1:0]             free_idx_q;
  logic [psqrl_pkg::TickW-1:0] oldest_age_q;
  logic [IdxW-1:0]             oldest_idx_q;
  logic                        hit_q;
  logic                        accepted_q;

  logic                        rd_en;
  logic [IdxW-1:0]             rd_idx;
  logic                        ev_en;
  logic [psqrl_pkg::TickW-1:0] age;
  logic                        live;
  logic                        match;
  logic [IdxW-1:0]             target;

  // Read issue: one entry per cycle while scanning
  assign rd_en  = cmd_i.scan && (rd_cnt_q < CntW'(TableDepth));
  assign rd_idx = rd_cnt_q[IdxW-1:0];

  // Evaluation of the entry read in the previous cycle
  assign ev_en = cmd_i.scan && ev_vld_q;
  assign age   = now_q - rd_stamp_q;
  assign live  = valid_q[ev_idx_q] && (age < window_q);
  assign match = live && (rd_addr_q == addr_q);

  assign status_o.hit  = ev_en && match;
  assign status_o.last = ev_en && (ev_idx_q == IdxW'(TableDepth - 1));

  // Free slot with the lowest index, else the oldest live entry
  assign target = free_found_q ? free_idx_q : oldest_idx_q;

  // Expired entries are freed, then the new entry claims its slot
  always_comb begin
    valid_d = valid_q;
    if (cmd_i.commit) begin
      valid_d         = live_q;
      valid_d[target] = 1'b1;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem_addr[target]  <= addr_q;
      mem_stamp[target] <= now_q;
    end
    if (rd_en) begin
      rd_addr_q  <= mem_addr[rd_idx];
      rd_stamp_q <= mem_stamp[rd_idx];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= psqrl_pkg::WindowReset;
      valid_q  <= '0;
      rd_cnt_q <= '0;
      ev_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      valid_q  <= valid_d;
      ev_vld_q <= rd_en;
      if (cmd_i.start) begin
        rd_cnt_q <= '0;
        hit_q    <= 1'b0;
      end else begin
        if (rd_en) begin
          rd_cnt_q <= rd_cnt_q + CntW'(1);
        end
        if (status_o.hit) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  // Request capture, scan trackers and output data
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      ev_idx_q <= rd_idx;
    end
    if (cmd_i.start) begin
      addr_q       <= source_address_i;
      now_q        <= now_ticks_i;
      free_found_q <= 1'b0;
    end else if (ev_en) begin
      live_q[ev_idx_q] <= live;
      if (!live && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= ev_idx_q;
      end
      // strictly older wins, so the lowest index keeps a tie
      if ((ev_idx_q == '0) || (age > oldest_age_q)) begin
        oldest_age_q <= age;
        oldest_idx_q <= ev_idx_q;
      end
    end
    if (cmd_i.load_out) begin
      accepted_q <= !hit_q;
    end
  end

  assign accepted_o = accepted_q;

endmodule

[src/per_source_query_rate_limiter.sv]
// Top level of the per-source query rate limiter.
//
//   channel  direction  handshake                  payload
//   in       request    in_valid_i / in_ready_o    source_address_i, now_ticks_i
//   out      result     out_valid_o / out_ready_i  accepted_o
//   cfg      write      cfg_we_i                   cfg_wdata_i (window_ticks)
//
// A request holds the block from acceptance to the next ready for the scan of
// the slot memory through its single read port; a live repeat found early
// ends the scan sooner.
// Reset clears the valid bits and sets the window to 5000 ticks; no sweep.
// The result waits in an output register; a new request is taken meanwhile,
// and its result is held back until the register is free.
module per_source_query_rate_limiter #(
  parameter int unsigned TableDepth = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [psqrl_pkg::AddrW-1:0] source_address_i,
  input  logic [psqrl_pkg::TickW-1:0] now_ticks_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        accepted_o,
  input  logic                        cfg_we_i,
  input  logic [psqrl_pkg::TickW-1:0] cfg_wdata_i
);

  psqrl_pkg::psqrl_cmd_t    cmd;
  psqrl_pkg::psqrl_status_t status;

  psqrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  psqrl_datapath #(
    .TableDepth (TableDepth)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .source_address_i (source_address_i),
    .now_ticks_i      (now_ticks_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .accepted_o       (accepted_o)
  );

`ifndef SYNTHESIS
  // one request in flight at a time
  a_single_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // a verdict never overwrites one still waiting
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("output register overwritten");

  // the scan starts only on an accepted request
  a_start_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> (in_valid_i && in_ready_o))
    else $error("scan started without a request");

  // a table write never follows a hit directly
  a_no_commit_after_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.hit |=> !cmd.commit)
    else $error("rejected request written into the table");
`endif

endmodule
